// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert with reset disable
`define BPA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// assert that is live during reset as well
`define BPA_ASSERT_NR(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Sizes, status codes and shared types of the page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

   localparam int NUM_PAGES   = 4096;
   localparam int PAGE_W      = 12;
   localparam int POS_W       = 13;
   localparam int COUNT_W     = 20;
   localparam int WORD_W      = 32;
   localparam int ROWS        = NUM_PAGES / WORD_W;
   localparam int ROW_W       = $clog2(ROWS);
   localparam int OFF_W       = $clog2(WORD_W);
   localparam int CHUNK_W     = 8;
   localparam int CHUNK_SH    = $clog2(CHUNK_W);
   localparam int CHUNK_IDX_W = OFF_W - CHUNK_SH;
   localparam int STATUS_W    = 2;

   localparam logic [POS_W-1:0]   PAGES_END       = POS_W'(NUM_PAGES);
   localparam logic [POS_W-1:0]   PIU_RESET       = POS_W'(4096);
   localparam logic [COUNT_W-1:0] MAX_ALLOC_COUNT = COUNT_W'(1024 * 256);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_MEMORY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ZERO      = 2'd3;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] end_page;
      logic [POS_W-1:0] run;
   } bpa_scan_res_type;

endpackage

`default_nettype wire

// ===== design/bpa_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying allocate and free requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpa_req_if import bpa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               op;
   logic [COUNT_W-1:0] page_count;
   logic [PAGE_W-1:0]  start_page;

   modport source (output valid, op, page_count, start_page, input ready);
   modport sink   (input valid, op, page_count, start_page, output ready);
endinterface

`default_nettype wire

// ===== design/bpa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one status beat per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpa_rsp_if import bpa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [PAGE_W-1:0]   alloc_page;

   modport source (output valid, status, alloc_page, input ready);
   modport sink   (input valid, status, alloc_page, output ready);
endinterface

`default_nettype wire

// ===== design/bitmap_page_allocator.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator
// Next-fit page allocator over a one-bit-per-page map held in a RAM.
// ----------------------------------------------------------------------------
// Zero-count, oversized and at-end requests go from accept to the result state.
// Alloc: per 32-bit map word scanned, one read and up to four 8-bit chunk steps;
//   then place, and per word marked a read and a write back, then the response.
// Free: a read and a write back per map word cleared, then the response.
// One request at a time; the map RAM read-modify-write sets the pace.
// Reset: per-row valid flags clear at once, unwritten rows read as allocated.
`default_nettype none

module bitmap_page_allocator import bpa_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [POS_W-1:0] csr_wdata,
   bpa_req_if.sink               req_ch,
   bpa_rsp_if.source             rsp_ch
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN_RD  = 3'd1;
   localparam logic [2:0] S_SCAN_CHK = 3'd2;
   localparam logic [2:0] S_PLACE    = 3'd3;
   localparam logic [2:0] S_MARK_RD  = 3'd4;
   localparam logic [2:0] S_MARK_WR  = 3'd5;
   localparam logic [2:0] S_RESULT   = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [POS_W-1:0]       piu_ff;
   logic [POS_W-1:0]       sp_ff, sp_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [POS_W-1:0]       run_ff, run_in;
   logic [ROW_W-1:0]       word_ff, word_in;
   logic [CHUNK_IDX_W-1:0] chunk_ff, chunk_in;
   logic [PAGE_W-1:0]      lo_ff, lo_in;
   logic [PAGE_W-1:0]      hi_ff, hi_in;
   logic                   set_ff, set_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [PAGE_W-1:0]      page_ff, page_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]      rsp_page_ff, rsp_page_in;
   logic [ROWS-1:0]        row_valid_ff;

   logic                   ram_we;
   logic [WORD_W-1:0]      ram_wdata;
   logic                   ram_re;
   logic [ROW_W-1:0]       ram_raddr;
   logic [WORD_W-1:0]      ram_rdata;
   logic [WORD_W-1:0]      row_data;
   logic [CHUNK_W-1:0]     chunk_bits;
   logic [POS_W-1:0]       limit;
   logic [POS_W-1:0]       chunk_base;
   logic [POS_W-1:0]       chunk_last;
   bpa_scan_res_type       scan_res;
   logic [OFF_W-1:0]       lo_off;
   logic [OFF_W-1:0]       hi_off;
   logic [WORD_W-1:0]      mask;
   logic [COUNT_W:0]       free_end;
   logic [POS_W-1:0]       place_lo;
   logic                   accept;
   logic                   rsp_free;

   bpa_ram #(
      .WIDTH(WORD_W),
      .DEPTH(ROWS)
   ) u_map_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (word_ff),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign limit      = (piu_ff > PAGES_END) ? PAGES_END : piu_ff;
   assign row_data   = row_valid_ff[word_ff] ? ram_rdata : '1;
   assign chunk_bits = row_data[{chunk_ff, {CHUNK_SH{1'b0}}} +: CHUNK_W];
   assign chunk_base = POS_W'({word_ff, chunk_ff, {CHUNK_SH{1'b0}}});
   assign chunk_last = chunk_base + POS_W'(CHUNK_W);

   bpa_scan u_scan (
      .bits       (chunk_bits),
      .base       (chunk_base),
      .search_pos (sp_ff),
      .limit      (limit),
      .count      (count_ff),
      .run_in     (run_ff),
      .res        (scan_res)
   );

   assign lo_off = (lo_ff[PAGE_W-1:OFF_W] == word_ff) ? lo_ff[OFF_W-1:0] : '0;
   assign hi_off = (hi_ff[PAGE_W-1:OFF_W] == word_ff) ? hi_ff[OFF_W-1:0] : '1;
   assign mask   = ({WORD_W{1'b1}} << lo_off) & ({WORD_W{1'b1}} >> (~hi_off));
   assign ram_wdata = set_ff ? (row_data | mask) : (row_data & ~mask);

   assign free_end = (COUNT_W+1)'(req_ch.start_page) + (COUNT_W+1)'(req_ch.page_count);
   assign place_lo = POS_W'({1'b0, hi_ff}) + POS_W'(1) - count_ff[POS_W-1:0];

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign ram_re    = (state_ff == S_SCAN_RD) || (state_ff == S_MARK_RD);
   assign ram_raddr = word_ff;
   assign ram_we    = (state_ff == S_MARK_WR);

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      count_in      = count_ff;
      run_in        = run_ff;
      word_in       = word_ff;
      chunk_in      = chunk_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      set_in        = set_ff;
      status_in     = status_ff;
      page_in       = page_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               count_in  = req_ch.page_count;
               page_in   = '0;
               status_in = STATUS_OK;
               run_in    = '0;
               if (req_ch.page_count == '0) begin
                  status_in = STATUS_ZERO;
                  state_in  = S_RESULT;
               end else if (req_ch.op == OP_FREE) begin
                  set_in   = 1'b0;
                  lo_in    = req_ch.start_page;
                  hi_in    = (free_end > (COUNT_W+1)'(NUM_PAGES)) ?
                             PAGE_W'(NUM_PAGES - 1) : PAGE_W'(free_end - 1'b1);
                  word_in  = req_ch.start_page[PAGE_W-1:OFF_W];
                  if (POS_W'(req_ch.start_page) < sp_ff) begin
                     sp_in = POS_W'(req_ch.start_page);
                  end
                  state_in = S_MARK_RD;
               end else if (req_ch.page_count > MAX_ALLOC_COUNT) begin
                  status_in = STATUS_TOO_LARGE;
                  state_in  = S_RESULT;
               end else if (sp_ff >= limit) begin
                  status_in = STATUS_NO_MEMORY;
                  state_in  = S_RESULT;
               end else begin
                  word_in  = sp_ff[PAGE_W-1:OFF_W];
                  chunk_in = sp_ff[OFF_W-1:CHUNK_SH];
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            run_in = scan_res.run;
            priority if (scan_res.found) begin
               hi_in    = scan_res.end_page[PAGE_W-1:0];
               sp_in    = scan_res.end_page + POS_W'(1);
               state_in = S_PLACE;
            end else if (chunk_last >= limit) begin
               sp_in     = limit;
               status_in = STATUS_NO_MEMORY;
               state_in  = S_RESULT;
            end else begin
               chunk_in = chunk_ff + 1'b1;
               if (chunk_ff == '1) begin
                  word_in  = word_ff + 1'b1;
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_PLACE: begin
            lo_in    = place_lo[PAGE_W-1:0];
            page_in  = place_lo[PAGE_W-1:0];
            word_in  = place_lo[PAGE_W-1:OFF_W];
            set_in   = 1'b1;
            state_in = S_MARK_RD;
         end
         S_MARK_RD: begin
            state_in = S_MARK_WR;
         end
         S_MARK_WR: begin
            if (word_ff == hi_ff[PAGE_W-1:OFF_W]) begin
               state_in = S_RESULT;
            end else begin
               word_in  = word_ff + 1'b1;
               state_in = S_MARK_RD;
            end
         end
         S_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_page_in   = page_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         piu_ff       <= PIU_RESET;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            piu_ff <= csr_wdata;
         end
         if (ram_we) begin
            row_valid_ff[word_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      run_ff        <= run_in;
      word_ff       <= word_in;
      chunk_ff      <= chunk_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      set_ff        <= set_in;
      status_ff     <= status_in;
      page_ff       <= page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.alloc_page = rsp_page_ff;

endmodule

`default_nettype wire

// ===== design/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/bpa_scan.sv =====
// ----------------------------------------------------------------------------
// Chunk scanner
// Walks one chunk of map bits, counting the free run and flagging a fit.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_scan import bpa_pkg::*; (
   input  wire logic [CHUNK_W-1:0] bits,
   input  wire logic [POS_W-1:0]   base,
   input  wire logic [POS_W-1:0]   search_pos,
   input  wire logic [POS_W-1:0]   limit,
   input  wire logic [COUNT_W-1:0] count,
   input  wire logic [POS_W-1:0]   run_in,
   output      bpa_scan_res_type   res
);

   logic [POS_W-1:0] page;
   logic [POS_W-1:0] run;
   logic             found;
   logic [POS_W-1:0] end_page;

   always_comb begin
      run      = run_in;
      found    = 1'b0;
      end_page = '0;
      page     = base;
      for (int b = 0; b < CHUNK_W; b++) begin
         page = base + POS_W'(b);
         if (!found && page >= search_pos && page < limit) begin
            if (bits[b]) begin
               run = '0;
            end else begin
               run = run + POS_W'(1);
               if (COUNT_W'(run) == count) begin
                  found    = 1'b1;
                  end_page = page;
               end
            end
         end
      end
      res.found    = found;
      res.end_page = end_page;
      res.run      = run;
   end

endmodule

`default_nettype wire

// ===== design/bpa_checker.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bpa_checker import bpa_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [PAGE_W-1:0]   rsp_alloc_page
);

   // hold a stalled response beat
   `BPA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_alloc_page), "stalled response beat changed")

   // drop the response after reset
   `BPA_ASSERT_NR(a_rsp_reset, clock, reset |=> !rsp_valid, "response valid after reset")

   // zero page on every response whose status is not OK
   `BPA_ASSERT(a_page_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK |-> rsp_alloc_page == '0, "page not zero on error")

   // take one request at a time
   `BPA_ASSERT(a_one_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready, "ready stayed high after accept")

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_alloc_page (rsp_ch.alloc_page)
);

`default_nettype wire

// ===== dv/bitmap_page_allocator_test.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives allocate and free requests through the request channel under several
// page limits and checks every response against a bit-level page map kept
// here. Both channel sides idle at random, and once the response side stalls
// long enough to back up the request side.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_test;
   import bpa_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int RUN_LIMIT       = 40_000_000;
   localparam int HOLD_CYCLES     = 600;
   localparam int ITEMS_PER_PHASE = 48;
   localparam int REPORT_MAX      = 10;
   localparam int DRAIN_CYCLES    = 50;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   alloc_page;
   } alloc_reply_type;

   class page_ledger_type;
      bit              page_taken [NUM_PAGES];
      int unsigned     search_pos;
      int unsigned     page_limit;
      alloc_reply_type awaited [$];
      int              errors;
      int              status_seen [4];

      function new();
         foreach (page_taken[p]) page_taken[p] = 1'b1;
         foreach (status_seen[s]) status_seen[s] = 0;
         search_pos = 0;
         page_limit = PIU_RESET;
         errors     = 0;
      endfunction

      function void set_page_limit(logic [POS_W-1:0] value);
         page_limit = value;
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction

      function void note_request(logic op, logic [COUNT_W-1:0] count,
                                 logic [PAGE_W-1:0] start);
         alloc_reply_type reply;
         int unsigned     limit;
         int unsigned     run;
         int unsigned     i;
         int unsigned     p;
         int unsigned     stop;
         bit              found;
         reply.status     = STATUS_OK;
         reply.alloc_page = '0;
         if (count == 0) begin
            reply.status = STATUS_ZERO;
         end else if (op == OP_ALLOC) begin
            if (count > MAX_ALLOC_COUNT) begin
               reply.status = STATUS_TOO_LARGE;
            end else begin
               limit = (page_limit > NUM_PAGES) ? NUM_PAGES : page_limit;
               run   = 0;
               found = 1'b0;
               for (i = search_pos; i < limit; i++) begin
                  if (page_taken[i]) begin
                     run = 0;
                  end else begin
                     run++;
                     if (run == count) begin
                        found = 1'b1;
                        break;
                     end
                  end
               end
               if (found) begin
                  reply.alloc_page = PAGE_W'(i - count + 1);
                  for (p = i - count + 1; p <= i; p++) page_taken[p] = 1'b1;
                  search_pos = i + 1;
               end else begin
                  reply.status = STATUS_NO_MEMORY;
                  if (search_pos < limit) search_pos = limit;
               end
            end
         end else begin
            stop = start + count;
            if (stop > NUM_PAGES) stop = NUM_PAGES;
            for (p = start; p < stop; p++) page_taken[p] = 1'b0;
            if (start < search_pos) search_pos = start;
         end
         status_seen[reply.status]++;
         awaited.push_back(reply);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status,
                                   logic [PAGE_W-1:0] page);
         alloc_reply_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("%0t: response beat with no request waiting: status %0d page %0d",
                        $time, status, page);
         end else begin
            want = awaited.pop_front();
            if (status !== want.status || page !== want.alloc_page) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("%0t: mismatch: status exp %0d got %0d, alloc_page exp %0d got %0d",
                           $time, want.status, status, want.alloc_page, page);
            end
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [POS_W-1:0] csr_wdata;

   bpa_req_if req_bus ();
   bpa_rsp_if rsp_bus ();

   page_ledger_type ledger;
   int              sender_idle_pct;
   int              receiver_idle_pct;
   bit              hold_request;
   int              limits_written;

   bitmap_page_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus)
   );

   always #HALF_PERIOD clock = ~clock;

   initial begin
      #RUN_LIMIT;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready)
         ledger.check_response(rsp_bus.status, rsp_bus.alloc_page);
   end

   task automatic send_request(logic op, logic [COUNT_W-1:0] count,
                               logic [PAGE_W-1:0] start);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.op         <= op;
      req_bus.page_count <= count;
      req_bus.start_page <= start;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      ledger.note_request(op, count, start);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (ledger.outstanding() != 0) @(negedge clock);
   endtask

   task automatic write_page_limit(logic [POS_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      ledger.set_page_limit(value);
      limits_written++;
   endtask

   task automatic send_random_request();
      int unsigned        pick;
      logic               op;
      logic [COUNT_W-1:0] count;
      logic [PAGE_W-1:0]  start;
      pick  = $urandom_range(0, 99);
      start = PAGE_W'($urandom);
      op    = OP_ALLOC;
      if (pick < 45) begin
         count = ($urandom_range(0, 9) < 8) ? COUNT_W'($urandom_range(1, 16)) :
                                              COUNT_W'($urandom_range(17, 300));
      end else if (pick < 80) begin
         op    = OP_FREE;
         count = ($urandom_range(0, 9) < 8) ? COUNT_W'($urandom_range(1, 64)) :
                                              COUNT_W'($urandom_range(65, 4096));
      end else if (pick < 86) begin
         op    = OP_FREE;
         count = COUNT_W'($urandom);
      end else if (pick < 91) begin
         op    = $urandom_range(0, 1) ? OP_FREE : OP_ALLOC;
         count = '0;
      end else if (pick < 96) begin
         count = COUNT_W'($urandom_range(MAX_ALLOC_COUNT + 1, 2 ** COUNT_W - 1));
      end else begin
         count = $urandom_range(0, 1) ? MAX_ALLOC_COUNT :
                                        COUNT_W'($urandom_range(301, MAX_ALLOC_COUNT));
      end
      send_request(op, count, start);
   endtask

   task automatic run_directed();
      send_request(OP_ALLOC, COUNT_W'(1), PAGE_W'($urandom));
      send_request(OP_ALLOC, '0, PAGE_W'($urandom));
      send_request(OP_FREE, '0, '0);
      send_request(OP_ALLOC, COUNT_W'(MAX_ALLOC_COUNT + 1), PAGE_W'($urandom));
      send_request(OP_ALLOC, '1, '1);
      send_request(OP_FREE, COUNT_W'(NUM_PAGES), '0);
      send_request(OP_ALLOC, MAX_ALLOC_COUNT, PAGE_W'($urandom));
      send_request(OP_FREE, '1, '1);
      send_request(OP_ALLOC, COUNT_W'(1), '0);
      send_request(OP_ALLOC, COUNT_W'(1), '0);
      send_request(OP_FREE, COUNT_W'(1), '0);
      send_request(OP_ALLOC, COUNT_W'(1), '1);
      send_request(OP_ALLOC, COUNT_W'(NUM_PAGES), '0);
      send_request(OP_FREE, COUNT_W'(NUM_PAGES / 2), PAGE_W'(NUM_PAGES / 2));
      send_request(OP_ALLOC, COUNT_W'(NUM_PAGES / 2 - 1), '0);
      send_request(OP_FREE, COUNT_W'(NUM_PAGES - 2), PAGE_W'(1));
      send_request(OP_ALLOC, COUNT_W'(NUM_PAGES - 2), '0);
      send_request(OP_FREE, COUNT_W'(NUM_PAGES), '0);
      send_request(OP_ALLOC, COUNT_W'(32), '0);
      send_request(OP_ALLOC, COUNT_W'(33), '0);
      send_request(OP_FREE, COUNT_W'(3), PAGE_W'(10));
      send_request(OP_ALLOC, COUNT_W'(3), '0);
   endtask

   initial begin
      logic [POS_W-1:0] limits [8];
      int               phase;
      clock              = 1'b0;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = PIU_RESET;
      req_bus.valid      = 1'b0;
      req_bus.op         = OP_ALLOC;
      req_bus.page_count = '0;
      req_bus.start_page = '0;
      hold_request       = 1'b0;
      limits_written     = 0;
      sender_idle_pct    = 7;
      receiver_idle_pct  = 74;
      ledger             = new();
      limits = '{POS_W'(0), '1, PIU_RESET, POS_W'(1), POS_W'($urandom_range(2, 4094)),
                 POS_W'(4095), POS_W'($urandom_range(4097, 8190)), PIU_RESET};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      for (phase = 0; phase < 8; phase++) begin
         if (phase >= 6) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end else if (phase >= 3) begin
            sender_idle_pct   = 74;
            receiver_idle_pct = 7;
         end
         write_page_limit(limits[phase]);
         if (phase == 6) hold_request = 1'b1;
         repeat (limits[phase] == 0 ? 20 : ITEMS_PER_PHASE) send_random_request();
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Checked %0d requests under %0d page limits, from 0 up to 8191.",
               ledger.status_seen[STATUS_OK] + ledger.status_seen[STATUS_TOO_LARGE] +
               ledger.status_seen[STATUS_NO_MEMORY] + ledger.status_seen[STATUS_ZERO],
               limits_written);
      $display("Outcomes: %0d ok, %0d too large, %0d out of memory, %0d zero count.",
               ledger.status_seen[STATUS_OK], ledger.status_seen[STATUS_TOO_LARGE],
               ledger.status_seen[STATUS_NO_MEMORY], ledger.status_seen[STATUS_ZERO]);
      if (ledger.errors == 0 && ledger.outstanding() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
